>>> hw/rtl/ulb_pkg.sv
package ulb_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int MAX_LINE      = 64;
  localparam int LINE_CNT_W    = $clog2(MAX_LINE + 1);

  localparam logic [1:0] ACT_RECV      = 2'd0;
  localparam logic [1:0] ACT_READ_BYTE = 2'd1;
  localparam logic [1:0] ACT_READ_LINE = 2'd2;

  localparam logic [7:0] CHAR_NUL = 8'd0;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_CR  = 8'd13;

  // source of the result byte
  localparam logic [1:0] SEL_NONE  = 2'd0;
  localparam logic [1:0] SEL_RDATA = 2'd1;
  localparam logic [1:0] SEL_PEND  = 2'd2;

  typedef struct packed {
    logic       recv;
    logic       pop;
    logic       load_pend;
    logic       dec_line;
    logic       emit;
    logic [1:0] sel;
    logic       last;
    logic       no_line;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic lc_zero;
    logic term;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/ulb_in_if.sv
interface ulb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

>>> hw/rtl/ulb_out_if.sv
interface ulb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       has_char;
  logic       last;
  logic       no_line;

  modport source (output valid, output data, output has_char, output last,
                  output no_line, input ready);
  modport sink (input valid, input data, input has_char, input last,
                input no_line, output ready);
endinterface

>>> hw/rtl/ulb_datapath.sv
module ulb_datapath
  import ulb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic [7:0] rx_byte,
  input  logic       out_ready,
  output status_t    sts,
  output logic       out_valid,
  output logic [7:0] out_data,
  output logic       out_has_char,
  output logic       out_last,
  output logic       out_no_line
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] wr_idx;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] wr_idx_inc;
  logic [AW-1:0] rd_idx_inc;
  logic [7:0]    line_count;
  logic [7:0]    rdata;
  logic [7:0]    pend;
  logic          full;
  logic          store;
  logic          out_free;

  assign wr_idx_inc = (wr_idx == IDX_LAST) ? '0 : wr_idx + 1'b1;
  assign rd_idx_inc = (rd_idx == IDX_LAST) ? '0 : rd_idx + 1'b1;
  assign full       = (wr_idx_inc == rd_idx);
  assign store      = cmd.recv && !full && (rx_byte != CHAR_NUL) && (rx_byte != CHAR_LF);
  assign out_free   = !out_valid || out_ready;

  assign sts.empty    = (wr_idx == rd_idx);
  assign sts.lc_zero  = (line_count == 8'd0);
  assign sts.term     = (rdata == CHAR_CR) || rdata[7];
  assign sts.out_free = out_free;

  // ring storage, read data registered on pop
  always_ff @(posedge clk) begin
    if (store) begin
      mem[wr_idx] <= rx_byte;
    end
    if (cmd.pop) begin
      rdata <= mem[rd_idx];
    end
    if (cmd.load_pend) begin
      pend <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx     <= '0;
      rd_idx     <= '0;
      line_count <= 8'd0;
    end else begin
      if (store) begin
        wr_idx <= wr_idx_inc;
      end
      if (cmd.pop) begin
        rd_idx <= rd_idx_inc;
      end
      if (store && (rx_byte == CHAR_CR)) begin
        line_count <= line_count + 8'd1;
      end else if (cmd.dec_line) begin
        line_count <= line_count - 8'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last    <= cmd.last;
      out_no_line <= cmd.no_line;
      case (cmd.sel)
        SEL_RDATA: begin
          out_data     <= rdata;
          out_has_char <= 1'b1;
        end
        SEL_PEND: begin
          out_data     <= pend;
          out_has_char <= 1'b1;
        end
        default: begin
          out_data     <= 8'd0;
          out_has_char <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/ulb_ctrl.sv
module ulb_ctrl
  import ulb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_action,
  input  status_t    sts,
  output logic       req_ready,
  output cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STAT   = 3'd1;
  localparam logic [2:0] S_BYTE   = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic                  pend_valid;
  logic                  pend_valid_next;
  logic [LINE_CNT_W-1:0] n;
  logic [LINE_CNT_W-1:0] n_next;
  logic                  flag;
  logic                  flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      n          <= '0;
      flag       <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      n          <= n_next;
      flag       <= flag_next;
    end
  end

  always_comb begin
    cmd             = '0;
    state_next      = state;
    pend_valid_next = pend_valid;
    n_next          = n;
    flag_next       = flag;
    req_ready       = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req_action)
            ACT_RECV: begin
              cmd.recv = 1'b1;
            end
            ACT_READ_BYTE: begin
              if (sts.empty) begin
                flag_next  = 1'b0;
                state_next = S_STAT;
              end else begin
                cmd.pop    = 1'b1;
                state_next = S_BYTE;
              end
            end
            ACT_READ_LINE: begin
              if (sts.lc_zero) begin
                flag_next  = 1'b1;
                state_next = S_STAT;
              end else begin
                pend_valid_next = 1'b0;
                n_next          = '0;
                state_next      = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_NONE;
          cmd.last    = 1'b1;
          cmd.no_line = flag;
          state_next  = S_IDLE;
        end
      end
      S_BYTE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_RDATA;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FETCH: begin
        if (sts.empty) begin
          state_next = S_FINISH;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.term) begin
          state_next = S_FINISH;
        end else if (!pend_valid || sts.out_free) begin
          // held byte is not the last one: send it, keep the new one
          if (pend_valid) begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_PEND;
          end
          cmd.load_pend   = 1'b1;
          pend_valid_next = 1'b1;
          n_next          = n + 1'b1;
          state_next      = (n == LINE_CNT_W'(MAX_LINE - 1)) ? S_FINISH : S_FETCH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.sel      = pend_valid ? SEL_PEND : SEL_NONE;
          cmd.last     = 1'b1;
          cmd.dec_line = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/uart_rx_line_buffer.sv
// receive ring buffer with line counting
// req channel: action 0 stores rx_byte (bytes 0 and 10 are dropped, and any
//   byte when the ring already holds DEPTH-1 bytes); a stored 13 counts a line.
//   action 1 pops one byte, action 2 pops one line, action 3 is ignored
// rsp channel: data, has_char, last, no_line; every read gives at least one
//   result and the final result of a read carries last
// a request is taken only while the controller is idle, one at a time
// receive: no result
// read byte: popped when taken, loaded once the result register is free
// read line: the request is taken, then each popped byte, the terminator
//   included, passes a fetch state (pop from the ring memory) and a check
//   state (test for a terminator), and a finish state ends the read; the
//   byte read from the ring memory is registered on pop, hence the check state
// a line read emits at most MAX_LINE bytes
// reset clears the indices, the line count and the result valid flag; ring
//   contents are not cleared and need no clearing pass
// a stalled rsp holds the result register and the controller waits, no
//   request is taken until the read in flight has loaded its last result
module uart_rx_line_buffer
  import ulb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  ulb_in_if.sink    req,
  ulb_out_if.source rsp
);

  cmd_t    cmd;
  status_t sts;

  // controller: sequences receive, byte read and line read
  ulb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .sts        (sts),
    .req_ready  (req.ready),
    .cmd        (cmd)
  );

  // datapath: ring memory, indices, line count, held byte and result register
  ulb_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rx_byte      (req.rx_byte),
    .out_ready    (rsp.ready),
    .sts          (sts),
    .out_valid    (rsp.valid),
    .out_data     (rsp.data),
    .out_has_char (rsp.has_char),
    .out_last     (rsp.last),
    .out_no_line  (rsp.no_line)
  );

endmodule

>>> verif/tb_uart_rx_line_buffer.sv
module tb_uart_rx_line_buffer;
  import ulb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // action code with no function, the block must swallow it silently
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RING_DEPTH = DEPTH_DEFAULT;
  // items still queued when the sender and receiver stop idling
  localparam int TAIL_ITEMS = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       has_char;
    logic       last;
    logic       no_line;
  } line_result_t;

  typedef struct {
    logic [1:0] action;
    logic [7:0] rx_byte;
    bit         hold;   // sender waits for every pending result before this one
  } uart_request_t;

  logic clk;
  logic rst;

  ulb_in_if  req_ch ();
  ulb_out_if rsp_ch ();

  uart_rx_line_buffer u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the receive ring
  logic [7:0] ring_mem [RING_DEPTH];
  int         wr_pos;
  int         rd_pos;
  logic [7:0] lines_stored;

  uart_request_t  pending_reqs [$];
  line_result_t   line_exp_q [$];
  int             mismatches;
  int             reqs_queued;
  bit             hold_next;
  bit             req_taken;
  int             gap_left;
  int             stall_left;
  int             src_mode;
  int             sink_mode;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // expected results of one accepted request, state updated in place
  // ---------------------------------------------------------------------------
  function automatic void predict_request(input logic [1:0] act, input logic [7:0] b);
    int         nxt;
    logic [7:0] c;
    logic [7:0] line_bytes [$];
    bit         stop;
    case (act)
      ACT_RECV: begin
        nxt = (wr_pos + 1) % RING_DEPTH;
        // nul and line feed never enter the ring, nor anything once it is full
        if (nxt != rd_pos && b != CHAR_NUL && b != CHAR_LF) begin
          ring_mem[wr_pos] = b;
          wr_pos = nxt;
          if (b == CHAR_CR) lines_stored++;
        end
      end
      ACT_READ_BYTE: begin
        if (wr_pos == rd_pos) begin
          line_exp_q.push_back(line_result_t'{CHAR_NUL, 1'b0, 1'b1, 1'b0});
        end else begin
          line_exp_q.push_back(line_result_t'{ring_mem[rd_pos], 1'b1, 1'b1, 1'b0});
          rd_pos = (rd_pos + 1) % RING_DEPTH;
        end
      end
      ACT_READ_LINE: begin
        if (lines_stored == 8'd0) begin
          line_exp_q.push_back(line_result_t'{CHAR_NUL, 1'b0, 1'b1, 1'b1});
        end else begin
          stop = 1'b0;
          while (line_bytes.size() < MAX_LINE && !stop) begin
            if (wr_pos == rd_pos) begin
              stop = 1'b1;
            end else begin
              c = ring_mem[rd_pos];
              rd_pos = (rd_pos + 1) % RING_DEPTH;
              // carriage return or any byte with the top bit set ends the line
              if (c == CHAR_CR || c[7]) stop = 1'b1;
              else line_bytes.push_back(c);
            end
          end
          lines_stored--;
          if (line_bytes.size() == 0) begin
            line_exp_q.push_back(line_result_t'{CHAR_NUL, 1'b0, 1'b1, 1'b0});
          end else begin
            foreach (line_bytes[i]) begin
              line_exp_q.push_back(line_result_t'{line_bytes[i], 1'b1,
                                   i == line_bytes.size() - 1, 1'b0});
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_request(input logic [1:0] act, input logic [7:0] b);
    pending_reqs.push_back('{act, b, hold_next});
    hold_next = 1'b0;
    // ignored codes and dropped bytes do not count as real work
    if (act != ACT_UNUSED && !(act == ACT_RECV && (b == CHAR_NUL || b == CHAR_LF)))
      reqs_queued++;
  endfunction

  // byte from 1 to 127 that neither terminates nor gets dropped
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 127)); while (b == CHAR_LF || b == CHAR_CR);
    return b;
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic bit roll_gap(input int mode);
    case (mode)
      1:       return $urandom_range(0, 7) == 0;
      2:       return $urandom_range(0, 2) == 0;
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: changes at the falling edge, holds valid until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : req_drive
    uart_request_t r;
    if ($urandom_range(0, 47) == 0) src_mode = $urandom_range(0, 2);
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_taken) begin
      // request still waiting for ready, keep it stable
    end else begin
      req_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() >= TAIL_ITEMS && roll_gap(src_mode)) begin
        gap_left = $urandom_range(0, 6);
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].hold && line_exp_q.size() != 0)) begin
        req_ch.valid <= 1'b0;
      end else begin
        r = pending_reqs.pop_front();
        req_ch.valid   <= 1'b1;
        req_ch.action  <= r.action;
        req_ch.rx_byte <= r.rx_byte;
      end
    end
  end

  // result receiver: stalls in bursts, none near the end
  always @(negedge clk) begin
    if ($urandom_range(0, 47) == 0) sink_mode = $urandom_range(0, 2);
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (pending_reqs.size() >= TAIL_ITEMS && roll_gap(sink_mode)) begin
      stall_left = $urandom_range(0, 6);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check results, then predict for any request taken at this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    line_result_t want;
    line_result_t got;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.data, rsp_ch.has_char, rsp_ch.last, rsp_ch.no_line};
        if (line_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: data %02h has_char %0b last %0b no_line %0b",
                     got.data, got.has_char, got.last, got.no_line);
        end else begin
          want = line_exp_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: data %02h/%02h has_char %0b/%0b last %0b/%0b no_line %0b/%0b (exp/got)",
                       want.data, got.data, want.has_char, got.has_char,
                       want.last, got.last, want.no_line, got.no_line);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        req_taken = 1'b1;
        predict_request(req_ch.action, req_ch.rx_byte);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stim
    int  kind;
    int  len;
    int  start_count;
    bit  mid_hold_done;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.action  = ACT_RECV;
    req_ch.rx_byte = CHAR_NUL;
    rsp_ch.ready   = 1'b0;
    wr_pos         = 0;
    rd_pos         = 0;
    lines_stored   = 8'd0;
    mismatches     = 0;
    reqs_queued    = 0;
    hold_next      = 1'b0;
    req_taken      = 1'b0;
    gap_left       = 0;
    stall_left     = 0;
    src_mode       = 1;
    sink_mode      = 1;
    mid_hold_done  = 1'b0;

    // directed: empty reads, zero line count, unused code, dropped bytes
    queue_request(ACT_READ_BYTE, 8'hFF);
    queue_request(ACT_READ_LINE, 8'h00);
    queue_request(ACT_UNUSED, 8'hFF);
    queue_request(ACT_RECV, CHAR_NUL);
    queue_request(ACT_RECV, CHAR_LF);
    // line cut short by a high byte, the rest stays in the ring
    queue_request(ACT_RECV, 8'h41);
    queue_request(ACT_RECV, 8'h7F);
    queue_request(ACT_RECV, 8'h80);
    queue_request(ACT_RECV, 8'h42);
    queue_request(ACT_RECV, CHAR_CR);
    queue_request(ACT_READ_LINE, 8'h00);
    queue_request(ACT_READ_LINE, 8'h00);
    // empty line: terminator right at the head
    queue_request(ACT_RECV, CHAR_CR);
    queue_request(ACT_READ_BYTE, 8'h00);
    queue_request(ACT_READ_LINE, 8'h00);
    // single reads, a stored return popped as plain data, extremes of the byte
    queue_request(ACT_RECV, 8'h01);
    queue_request(ACT_RECV, 8'hFF);
    queue_request(ACT_READ_BYTE, 8'h00);
    queue_request(ACT_READ_BYTE, 8'h00);
    queue_request(ACT_READ_BYTE, 8'h00);
    queue_request(ACT_READ_BYTE, 8'h00);
    // line count set but the ring runs dry before a terminator
    queue_request(ACT_RECV, CHAR_CR);
    queue_request(ACT_READ_BYTE, 8'h00);
    queue_request(ACT_RECV, 8'h78);
    queue_request(ACT_READ_LINE, 8'h00);

    // random part, mostly whole lines with random text
    hold_next = 1'b1;
    start_count = reqs_queued;
    while (reqs_queued - start_count < 230) begin
      if (!mid_hold_done && reqs_queued - start_count >= 115) begin
        hold_next = 1'b1;
        mid_hold_done = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        for (int j = 0; j < len; j++) queue_request(ACT_RECV, text_byte());
        queue_request(ACT_RECV, CHAR_CR);
        if ($urandom_range(0, 3) != 0) queue_request(ACT_READ_LINE, any_byte());
      end else if (kind < 65) begin
        queue_request(ACT_READ_LINE, any_byte());
      end else if (kind < 77) begin
        len = $urandom_range(1, 3);
        for (int j = 0; j < len; j++) queue_request(ACT_READ_BYTE, any_byte());
      end else if (kind < 87) begin
        // noise over the whole input space
        len = $urandom_range(1, 4);
        for (int j = 0; j < len; j++) queue_request(2'($urandom_range(0, 3)), any_byte());
      end else if (kind < 93) begin
        // broken line: a high byte in the middle of the text
        len = $urandom_range(0, 6);
        for (int j = 0; j < len; j++) queue_request(ACT_RECV, text_byte());
        queue_request(ACT_RECV, 8'($urandom_range(128, 255)));
        len = $urandom_range(0, 6);
        for (int j = 0; j < len; j++) queue_request(ACT_RECV, text_byte());
        queue_request(ACT_RECV, CHAR_CR);
        queue_request(ACT_READ_LINE, any_byte());
      end else begin
        // overrun: more bytes than the ring holds, then drain some lines
        for (int j = 0; j < 70; j++) queue_request(ACT_RECV, text_byte());
        queue_request(ACT_RECV, CHAR_CR);
        for (int j = 0; j < 3; j++) queue_request(ACT_READ_LINE, any_byte());
      end
    end
    // read up to four more lines before the run ends
    for (int j = 0; j < 4; j++) queue_request(ACT_READ_LINE, any_byte());

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_ch.valid || line_exp_q.size() != 0)
      @(posedge clk);
    // a late or extra result would show up within this window
    repeat (40) @(posedge clk);

    if (mismatches == 0 && line_exp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
